// ===== hdl/assert_macros.svh =====
// Assertion macros for a module that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/wplc_pkg.sv =====
// Shared types, widths, constants and tables of the waypoint pursuit lap controller.
package wplc_pkg;

    localparam int POSITION_BITS = 20;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);

    // Field widths that are fixed.
    localparam int YAW_W   = 15;
    localparam int TIME_W  = 16;
    localparam int PEND_W  = 17;
    localparam int DT_W    = 18;
    localparam int LIN_W   = 13;
    localparam int ANG_W   = 15;
    localparam int DIST_W  = 24;
    localparam int STAT_W  = 2;
    localparam int LGAIN_W = 12;
    localparam int AGAIN_W = 12;
    localparam int AMAX_W  = 14;
    localparam int RAD_W   = 16;

    // Datapath widths.
    localparam int OFF_W   = POSITION_BITS + 1;
    localparam int CW      = POSITION_BITS + 4;
    localparam int Z_W     = 21;
    localparam int ERR_W   = 22;
    localparam int PROD_W  = CW - 1 + 24;
    localparam int MAG_W   = CW;
    localparam int LPROD_W = LGAIN_W + MAG_W;
    localparam int APROD_W = AGAIN_W + 1 + ERR_W;
    localparam int IPROD_W = LIN_W + DT_W;

    localparam logic signed [Z_W-1:0] PI_Q16       = Z_W'(205887);
    localparam logic [23:0]           INV_GAIN_Q24 = 24'd10188014;
    localparam logic [PEND_W-1:0]     PEND_MAX     = '1;
    localparam logic [DIST_W-1:0]     DIST_MAX     = '1;

    // Stream packing.
    localparam int RX_LSB     = 0;
    localparam int RY_LSB     = POSITION_BITS;
    localparam int YAW_LSB    = 2 * POSITION_BITS;
    localparam int WX_LSB     = 2 * POSITION_BITS + YAW_W;
    localparam int WY_LSB     = 3 * POSITION_BITS + YAW_W;
    localparam int EL_LSB     = 4 * POSITION_BITS + YAW_W;
    localparam int IN_DATA_W  = ((4 * POSITION_BITS + YAW_W + TIME_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_LIN_LSB  = 0;
    localparam int OUT_ANG_LSB  = LIN_W;
    localparam int OUT_DIST_LSB = LIN_W + ANG_W;
    localparam int OUT_DATA_W = ((LIN_W + ANG_W + DIST_W + 7) / 8) * 8;
    localparam int OUT_USER_W = STAT_W;

    // Configuration port.
    localparam int ADDR_W = 5;
    localparam int APB_W  = 32;

    typedef enum logic [2:0] {
        REG_LINEAR_GAIN,
        REG_ANGULAR_GAIN,
        REG_MAX_LINEAR,
        REG_MAX_ANGULAR,
        REG_STOP_RADIUS,
        REG_LAP_MIN,
        REG_HOME_RADIUS
    } t_reg;

    typedef enum logic [1:0] {
        ACT_START,
        ACT_TICK,
        ACT_CANCEL
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_RUNNING,
        ST_LAP,
        ST_CANCELED
    } t_status;

    typedef struct packed {
        logic [LGAIN_W-1:0] linear_gain;
        logic [AGAIN_W-1:0] angular_gain;
        logic [LIN_W-1:0]   max_linear_speed;
        logic [AMAX_W-1:0]  max_angular_speed;
        logic [RAD_W-1:0]   stop_radius;
        logic [DIST_W-1:0]  lap_min_distance;
        logic [RAD_W-1:0]   home_radius;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic abort;
        logic cancel;
        logic pend;
        logic cord_init;
        logic cord_sel;
        logic cord_step;
        logic mag_mul;
        logic mag_fin;
        logic err;
        logic mul;
        logic clamp;
        logic inc;
        logic accum;
        logic decide;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       pose_valid;
        logic       running;
        logic       out_free;
        logic       cord_last;
        logic       sel;
    } t_stat;

    // Arctangent of 2^-i in Q.16 radians.
    function automatic logic [15:0] atan_q16(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/wplc_regs.sv =====
// Configuration register file behind the APB-style port.
module wplc_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wplc_pkg::ADDR_W-1:0]   paddr,
    input  logic [wplc_pkg::APB_W-1:0]    pwdata,
    output logic [wplc_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output wplc_pkg::t_cfg                o_cfg
);

    wplc_pkg::t_cfg r_cfg;
    wplc_pkg::t_reg w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = wplc_pkg::t_reg'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_gain       <= 12'd128;
            r_cfg.angular_gain      <= 12'd384;
            r_cfg.max_linear_speed  <= 13'd1229;
            r_cfg.max_angular_speed <= 14'd4096;
            r_cfg.stop_radius       <= 16'd205;
            r_cfg.lap_min_distance  <= 24'd8192;
            r_cfg.home_radius       <= 16'd819;
        end else if (w_wr) begin
            case (w_idx)
                wplc_pkg::REG_LINEAR_GAIN:  r_cfg.linear_gain       <= pwdata[11:0];
                wplc_pkg::REG_ANGULAR_GAIN: r_cfg.angular_gain      <= pwdata[11:0];
                wplc_pkg::REG_MAX_LINEAR:   r_cfg.max_linear_speed  <= pwdata[12:0];
                wplc_pkg::REG_MAX_ANGULAR:  r_cfg.max_angular_speed <= pwdata[13:0];
                wplc_pkg::REG_STOP_RADIUS:  r_cfg.stop_radius       <= pwdata[15:0];
                wplc_pkg::REG_LAP_MIN:      r_cfg.lap_min_distance  <= pwdata[23:0];
                wplc_pkg::REG_HOME_RADIUS:  r_cfg.home_radius       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            wplc_pkg::REG_LINEAR_GAIN:  prdata = 32'(r_cfg.linear_gain);
            wplc_pkg::REG_ANGULAR_GAIN: prdata = 32'(r_cfg.angular_gain);
            wplc_pkg::REG_MAX_LINEAR:   prdata = 32'(r_cfg.max_linear_speed);
            wplc_pkg::REG_MAX_ANGULAR:  prdata = 32'(r_cfg.max_angular_speed);
            wplc_pkg::REG_STOP_RADIUS:  prdata = 32'(r_cfg.stop_radius);
            wplc_pkg::REG_LAP_MIN:      prdata = 32'(r_cfg.lap_min_distance);
            wplc_pkg::REG_HOME_RADIUS:  prdata = 32'(r_cfg.home_radius);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== hdl/wplc_datapath.sv =====
// Datapath: item registers, lap state, shared CORDIC unit, gains, clamps and result register.
module wplc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wplc_pkg::t_cfg                    i_cfg,
    input  wplc_pkg::t_cmd                    i_cmd,
    output wplc_pkg::t_stat                   o_stat,
    input  logic [wplc_pkg::IN_DATA_W-1:0]    i_tdata,
    input  logic [wplc_pkg::IN_USER_W-1:0]    i_tuser,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [wplc_pkg::OUT_DATA_W-1:0]   o_tdata,
    output logic [wplc_pkg::OUT_USER_W-1:0]   o_tuser
);

    localparam int P         = wplc_pkg::POSITION_BITS;
    localparam int OFF_W     = wplc_pkg::OFF_W;
    localparam int CW        = wplc_pkg::CW;
    localparam int Z_W       = wplc_pkg::Z_W;
    localparam int ERR_W     = wplc_pkg::ERR_W;
    localparam int PROD_W    = wplc_pkg::PROD_W;
    localparam int MAG_W     = wplc_pkg::MAG_W;
    localparam int LPROD_W   = wplc_pkg::LPROD_W;
    localparam int APROD_W   = wplc_pkg::APROD_W;
    localparam int IPROD_W   = wplc_pkg::IPROD_W;
    localparam int LIN_RAW_W = LPROD_W + 1 - 8;
    localparam int ANG_RAW_W = APROD_W + 1 - 12;
    localparam int LIN_W     = wplc_pkg::LIN_W;
    localparam int ANG_W     = wplc_pkg::ANG_W;
    localparam int DIST_W    = wplc_pkg::DIST_W;
    localparam logic signed [ERR_W-1:0] PI_E     = ERR_W'(wplc_pkg::PI_Q16);
    localparam logic signed [ERR_W-1:0] TWO_PI_E = ERR_W'(2 * 205887);

    // Item registers.
    logic [1:0]                       r_act;
    logic                             r_valid;
    logic signed [P-1:0]              r_rx, r_ry, r_wx, r_wy;
    logic signed [wplc_pkg::YAW_W-1:0] r_yaw;
    logic [wplc_pkg::TIME_W-1:0]      r_elapsed;

    // Lap state.
    logic                             r_running;
    logic signed [P-1:0]              r_sx, r_sy;
    logic [DIST_W-1:0]                r_dtot;
    logic [wplc_pkg::PEND_W-1:0]      r_pend;

    // CORDIC unit.
    logic                             r_sel;
    logic                             r_zero;
    logic [wplc_pkg::STEP_W-1:0]      r_step;
    logic signed [CW-1:0]             r_cx, r_cy;
    logic signed [Z_W-1:0]            r_cz;
    logic [PROD_W-1:0]                r_prod;

    // Command arithmetic.
    logic [MAG_W-1:0]                 r_dist, r_home;
    logic signed [Z_W-1:0]            r_bearing;
    logic signed [ERR_W-1:0]          r_err;
    logic [LPROD_W-1:0]               r_lprod;
    logic signed [APROD_W-1:0]        r_aprod;
    logic [LIN_W-1:0]                 r_lin;
    logic signed [ANG_W-1:0]          r_ang;
    logic [wplc_pkg::DT_W-1:0]        r_dt;
    logic [IPROD_W-1:0]               r_iprod;

    // Result register.
    logic                             r_out_valid;
    logic [LIN_W-1:0]                 r_out_lin;
    logic signed [ANG_W-1:0]          r_out_ang;
    logic [DIST_W-1:0]                r_out_dist;
    logic [wplc_pkg::STAT_W-1:0]      r_out_stat;

    logic signed [OFF_W-1:0]          w_off_x, w_off_y;
    logic signed [CW-1:0]             w_xs, w_ys;
    logic signed [Z_W-1:0]            w_atan;
    logic [CW-2:0]                    w_xpos;
    logic [PROD_W:0]                  w_mag_sum;
    logic [MAG_W-1:0]                 w_mag;
    logic signed [ERR_W-1:0]          w_err0;
    logic [LPROD_W:0]                 w_lin_sum;
    logic [LIN_RAW_W-1:0]             w_lin_raw;
    logic [LIN_W-1:0]                 w_lin;
    logic signed [APROD_W:0]          w_ang_sum;
    logic signed [ANG_RAW_W-1:0]      w_ang_raw, w_amax, w_amin, w_ang;
    logic                             w_go;
    logic [wplc_pkg::PEND_W:0]        w_pend_sum;
    logic [DIST_W:0]                  w_acc;
    logic                             w_lap;

    function automatic logic signed [ERR_W-1:0] wrap_angle(input logic signed [ERR_W-1:0] a);
        logic signed [ERR_W-1:0] v;
        v = a;
        for (int k = 0; k < 4; k++) begin
            if (v > PI_E) begin
                v = v - TWO_PI_E;
            end else if (v < -PI_E) begin
                v = v + TWO_PI_E;
            end
        end
        return v;
    endfunction

    assign w_off_x = i_cmd.cord_sel ? OFF_W'(r_sx) - OFF_W'(r_rx) : OFF_W'(r_wx) - OFF_W'(r_rx);
    assign w_off_y = i_cmd.cord_sel ? OFF_W'(r_sy) - OFF_W'(r_ry) : OFF_W'(r_wy) - OFF_W'(r_ry);
    assign w_xs    = r_cx >>> r_step;
    assign w_ys    = r_cy >>> r_step;
    assign w_atan  = signed'(Z_W'(wplc_pkg::atan_q16(5'(r_step))));

    assign w_xpos    = r_cx[CW-1] ? '0 : r_cx[CW-2:0];
    assign w_mag_sum = (PROD_W+1)'(r_prod) + (PROD_W+1)'(1 << 23);
    assign w_mag     = r_zero ? '0 : w_mag_sum[PROD_W:24];

    assign w_err0 = ERR_W'(r_bearing) - (ERR_W'(r_yaw) <<< 4);

    assign w_go      = r_dist >= MAG_W'(i_cfg.stop_radius);
    assign w_lin_sum = (LPROD_W+1)'(r_lprod) + (LPROD_W+1)'(128);
    assign w_lin_raw = w_lin_sum[LPROD_W:8];
    assign w_lin     = (w_lin_raw > LIN_RAW_W'(i_cfg.max_linear_speed)) ?
                       i_cfg.max_linear_speed : w_lin_raw[LIN_W-1:0];
    assign w_ang_sum = (APROD_W+1)'(r_aprod) + (APROD_W+1)'(2048);
    assign w_ang_raw = w_ang_sum[APROD_W:12];
    assign w_amax    = signed'(ANG_RAW_W'(i_cfg.max_angular_speed));
    assign w_amin    = -w_amax;
    assign w_ang     = (w_ang_raw > w_amax) ? w_amax :
                       (w_ang_raw < w_amin) ? w_amin : w_ang_raw;

    assign w_pend_sum = (wplc_pkg::PEND_W+1)'(r_pend) + (wplc_pkg::PEND_W+1)'(r_elapsed);
    assign w_acc      = (DIST_W+1)'(r_dtot) + (DIST_W+1)'(r_iprod[IPROD_W-1:10]);
    assign w_lap      = (r_dtot > i_cfg.lap_min_distance) &&
                        (r_home < MAG_W'(i_cfg.home_radius));

    // Item and arithmetic registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_tuser[1:0];
            r_valid   <= i_tuser[2];
            r_rx      <= signed'(i_tdata[wplc_pkg::RX_LSB +: P]);
            r_ry      <= signed'(i_tdata[wplc_pkg::RY_LSB +: P]);
            r_yaw     <= signed'(i_tdata[wplc_pkg::YAW_LSB +: wplc_pkg::YAW_W]);
            r_wx      <= signed'(i_tdata[wplc_pkg::WX_LSB +: P]);
            r_wy      <= signed'(i_tdata[wplc_pkg::WY_LSB +: P]);
            r_elapsed <= i_tdata[wplc_pkg::EL_LSB +: wplc_pkg::TIME_W];
        end
        if (i_cmd.cord_init) begin
            r_sel  <= i_cmd.cord_sel;
            r_step <= '0;
            r_zero <= (w_off_x == '0) && (w_off_y == '0);
            // A vector in the left half plane is turned by pi first.
            if (w_off_x < 0) begin
                r_cx <= -CW'(w_off_x);
                r_cy <= -CW'(w_off_y);
                r_cz <= (w_off_y >= 0) ? wplc_pkg::PI_Q16 : -wplc_pkg::PI_Q16;
            end else begin
                r_cx <= CW'(w_off_x);
                r_cy <= CW'(w_off_y);
                r_cz <= '0;
            end
        end else if (i_cmd.cord_step) begin
            r_step <= r_step + 1'b1;
            if (!r_cy[CW-1]) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end
        end
        if (i_cmd.mag_mul) begin
            r_prod <= w_xpos * wplc_pkg::INV_GAIN_Q24;
        end
        if (i_cmd.mag_fin) begin
            if (r_sel) begin
                r_home <= w_mag;
            end else begin
                r_dist    <= w_mag;
                r_bearing <= r_zero ? '0 : r_cz;
            end
        end
        if (i_cmd.err) begin
            r_err <= wrap_angle(w_err0);
        end
        if (i_cmd.mul) begin
            r_lprod <= LPROD_W'(i_cfg.linear_gain) * LPROD_W'(r_dist);
            r_aprod <= APROD_W'(signed'({1'b0, i_cfg.angular_gain})) * APROD_W'(r_err);
        end
        if (i_cmd.clamp) begin
            r_lin <= w_go ? w_lin : '0;
            r_ang <= w_go ? w_ang[ANG_W-1:0] : '0;
            r_dt  <= wplc_pkg::DT_W'(r_pend) + wplc_pkg::DT_W'(r_elapsed);
        end
        if (i_cmd.inc) begin
            r_iprod <= IPROD_W'(r_lin) * IPROD_W'(r_dt);
        end
        if (i_cmd.cancel) begin
            r_out_lin  <= '0;
            r_out_ang  <= '0;
            r_out_dist <= r_dtot;
            r_out_stat <= wplc_pkg::ST_CANCELED;
        end else if (i_cmd.decide) begin
            r_out_lin  <= w_lap ? '0 : r_lin;
            r_out_ang  <= w_lap ? '0 : r_ang;
            r_out_dist <= r_dtot;
            r_out_stat <= w_lap ? wplc_pkg::ST_LAP : wplc_pkg::ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_dtot      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_running <= 1'b1;
                r_sx      <= r_rx;
                r_sy      <= r_ry;
                r_dtot    <= '0;
                r_pend    <= '0;
            end
            if (i_cmd.abort) begin
                r_running <= 1'b0;
            end
            if (i_cmd.cancel) begin
                r_running <= 1'b0;
                r_pend    <= '0;
            end
            if (i_cmd.pend) begin
                r_pend <= w_pend_sum[wplc_pkg::PEND_W] ?
                          wplc_pkg::PEND_MAX : w_pend_sum[wplc_pkg::PEND_W-1:0];
            end
            if (i_cmd.clamp) begin
                r_pend <= '0;
            end
            if (i_cmd.accum) begin
                r_dtot <= w_acc[DIST_W] ? wplc_pkg::DIST_MAX : w_acc[DIST_W-1:0];
            end
            if (i_cmd.decide && w_lap) begin
                r_running <= 1'b0;
            end
            if (i_cmd.cancel || i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.action     = r_act;
    assign o_stat.pose_valid = r_valid;
    assign o_stat.running    = r_running;
    assign o_stat.out_free   = !r_out_valid;
    assign o_stat.cord_last  = (r_step == wplc_pkg::STEP_W'(wplc_pkg::CORDIC_STEPS - 1));
    assign o_stat.sel        = r_sel;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = wplc_pkg::OUT_DATA_W'({r_out_dist, r_out_ang, r_out_lin});
    assign o_tuser  = r_out_stat;

endmodule

// ===== hdl/wplc_ctrl.sv =====
// Controller state machine that sequences the datapath through one item.
module wplc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    input  wplc_pkg::t_stat i_stat,
    output logic            o_ready,
    output wplc_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CORD,
        S_MAG_MUL,
        S_MAG_FIN,
        S_ERR,
        S_MUL,
        S_CLAMP,
        S_INC,
        S_ACC,
        S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    assign o_ready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (r_ready && i_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (wplc_pkg::t_action'(i_stat.action))
                    wplc_pkg::ACT_START: begin
                        o_cmd.start = i_stat.pose_valid;
                        o_cmd.abort = !i_stat.pose_valid;
                        n_state     = S_IDLE;
                    end
                    wplc_pkg::ACT_CANCEL: begin
                        if (!i_stat.running) begin
                            n_state = S_IDLE;
                        end else if (i_stat.out_free) begin
                            o_cmd.cancel = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    wplc_pkg::ACT_TICK: begin
                        if (!i_stat.running) begin
                            n_state = S_IDLE;
                        end else if (!i_stat.pose_valid) begin
                            o_cmd.pend = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.cord_init = 1'b1;
                            n_state         = S_CORD;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                if (i_stat.cord_last) begin
                    n_state = S_MAG_MUL;
                end
            end
            S_MAG_MUL: begin
                o_cmd.mag_mul = 1'b1;
                n_state       = S_MAG_FIN;
            end
            S_MAG_FIN: begin
                o_cmd.mag_fin = 1'b1;
                n_state       = i_stat.sel ? S_DECIDE : S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_INC;
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                // The home distance vectoring starts while the travel sum settles.
                o_cmd.accum     = 1'b1;
                o_cmd.cord_init = 1'b1;
                o_cmd.cord_sel  = 1'b1;
                n_state         = S_CORD;
            end
            S_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ===== hdl/waypoint_pursuit_lap_controller.sv =====
// Top level of the waypoint pursuit lap controller.
// Items enter on the slave stream (i_tvalid, o_tready, i_tdata, i_tuser) and
// results leave on the master stream (o_tvalid, i_tready, o_tdata, o_tuser).
// Gains, clamps and radii sit in an APB-style register file; the user must
// write it only while the block is idle, which the block does not enforce.
// A start, an abort, an ignored item or a tick without a valid pose passes
// only through the decode state, during which o_tready is low. A cancel while
// running does the same once the output register is free, waits in decode
// while it is full, and puts its result in the output register.
// A tick with a valid pose runs decode, two CORDIC vectorings of CORDIC_STEPS
// iterations each on one shared shift-add unit, magnitude scaling, heading
// error, multiply, clamp and travel update; its result appears in the output
// register and o_tready rises with it.
// The result waits in an output register; the next item is accepted while it
// waits, and the block stalls only when a second result is ready before the
// first was taken.
// Reset clears the lap state and the output valid flag, loads the register
// file defaults; o_tready rises at the clock edge after reset is released.
module waypoint_pursuit_lap_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    // robot_x, robot_y, robot_yaw, waypoint_x, waypoint_y, elapsed_time
    input  logic [wplc_pkg::IN_DATA_W-1:0]    i_tdata,
    // action, pose_valid
    input  logic [wplc_pkg::IN_USER_W-1:0]    i_tuser,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    // linear_command, angular_command, travelled_distance
    output logic [wplc_pkg::OUT_DATA_W-1:0]   o_tdata,
    // status
    output logic [wplc_pkg::OUT_USER_W-1:0]   o_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wplc_pkg::ADDR_W-1:0]       paddr,
    input  logic [wplc_pkg::APB_W-1:0]        pwdata,
    output logic [wplc_pkg::APB_W-1:0]        prdata,
    output logic                              pready
);

`include "assert_macros.svh"

    wplc_pkg::t_cfg  w_cfg;
    wplc_pkg::t_cmd  w_cmd;
    wplc_pkg::t_stat w_stat;

    wplc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wplc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_tvalid),
        .i_stat   (w_stat),
        .o_ready  (o_tready),
        .o_cmd    (w_cmd)
    );

    wplc_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_tdata  (i_tdata),
        .i_tuser  (i_tuser),
        .o_tvalid (o_tvalid),
        .i_tready (i_tready),
        .o_tdata  (o_tdata),
        .o_tuser  (o_tuser)
    );

    `ASSERT_NEXT(a_busy_after_item, i_tvalid && o_tready, !o_tready, "ready after an item")
    `ASSERT_ALWAYS(a_lap_zero_cmd, !(o_tvalid && o_tuser == wplc_pkg::ST_LAP) || (o_tdata[27:0] == 28'd0), "lap result with a command")
    `ASSERT_ALWAYS(a_cancel_zero_cmd, !(o_tvalid && o_tuser == wplc_pkg::ST_CANCELED) || (o_tdata[27:0] == 28'd0), "cancel result with a command")
    `ASSERT_ALWAYS(a_lin_clamped, !o_tvalid || (o_tdata[12:0] <= w_cfg.max_linear_speed), "speed above clamp")

endmodule
